FILE: rtl/gts_pkg.sv
// Package for the GF(2) tensor span tracker: request and response structs,
// codes, reset constants and small helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gts_pkg;

  // Default capacities of the two echelon bases.
  localparam int LINE_CAP_DEF = 8;
  localparam int SUM_CAP_DEF  = 12;

  // Reset values of the target registers.
  localparam logic [3:0][15:0] RESET_TARGETS = {16'h8200, 16'h4100, 16'h0082, 16'h0041};
  localparam logic [2:0]       RESET_TCOUNT  = 3'd4;
  localparam logic [2:0]       MAX_TARGETS   = 3'd4;

  // Request function codes.
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_DEP  = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_EXT  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_TVEC0  = 3'd0;
  localparam logic [2:0] REG_TVEC1  = 3'd1;
  localparam logic [2:0] REG_TVEC2  = 3'd2;
  localparam logic [2:0] REG_TVEC3  = 3'd3;
  localparam logic [2:0] REG_TCOUNT = 3'd4;

  typedef struct packed {
    logic       func;
    logic [3:0] left_factor;
    logic [3:0] right_factor;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] line_count;
    logic [3:0] sum_dim;
    logic [3:0] hit_count;
  } out_rsp_t;

  // One stored basis vector with its pivot (lowest set bit).
  typedef struct packed {
    logic [15:0] vec;
    logic [3:0]  piv;
  } basis_entry_t;

  // Result of one elimination step.
  typedef struct packed {
    logic [15:0] vec;
    logic [3:0]  low_bit;
    logic        is_zero;
  } step_res_t;

  // Tensor product: bit 4*i+j is a[i] AND b[j].
  function automatic logic [15:0] outer_product(input logic [3:0] a, input logic [3:0] b);
    logic [15:0] t;
    t = '0;
    for (int i = 0; i < 4; i++) begin
      t[4*i +: 4] = a[i] ? b : 4'h0;
    end
    return t;
  endfunction

  // Clamp a count to the four-bit output range.
  function automatic logic [3:0] sat15(input logic [4:0] x);
    return x[4] ? 4'hF : x[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gts_step_unit.sv
// Shared elimination step: clears the pivot bit of the working vector with
// one basis entry, and finds the lowest set bit. Uses gts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gts_step_unit (
  input  wire logic [15:0]          vec,
  input  wire gts_pkg::basis_entry_t entry,
  input  wire logic                 apply,
  output gts_pkg::step_res_t        res
);

  logic [3:0] low;

  // Lowest set bit of the incoming vector, zero when the vector is zero.
  always_comb begin
    low = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (vec[i]) begin
        low = 4'(i);
      end
    end
  end

  // Add the basis vector when the working vector has its pivot set.
  always_comb begin
    res.vec     = (apply && vec[entry.piv]) ? (vec ^ entry.vec) : vec;
    res.low_bit = low;
    res.is_zero = (vec == 16'h0000);
  end

endmodule

`default_nettype wire

FILE: rtl/gts_basis_file.sv
// Small register file holding one echelon basis: one write and one read
// port, read registered. Uses gts_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module gts_basis_file #(
  parameter int DEPTH = gts_pkg::LINE_CAP_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire gts_pkg::basis_entry_t wdata,
  input  wire logic [AW-1:0]         raddr,
  output gts_pkg::basis_entry_t      rdata
);

  gts_pkg::basis_entry_t mem [DEPTH];
  gts_pkg::basis_entry_t rdata_r;

  // Write port; entries are valid only below the owner's fill count.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered, zero outside the array.
  always_ff @(posedge clk) begin
    if (32'(raddr) < DEPTH) begin
      rdata_r <= mem[raddr];
    end else begin
      rdata_r <= '0;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/gf2_tensor_span_tracker.sv
// Top level of the GF(2) tensor span tracker: sequencer, counters, target
// registers and output register. Uses gts_pkg, gts_step_unit, gts_basis_file.
//
// Usage: a request on in_* (valid/ready) either inserts the line
// left_factor (x) right_factor or restarts the tracker from the target
// registers. Every request gives exactly one response on out_* with a
// status and the line, sum and hit counts after the request.
// The cfg_* port writes the target registers with no handshake; new values
// are used at the next restart request.
// Timing: one request at a time. An independent insert is answered after
// the shared step unit walks the line basis and then the sum basis one
// entry per cycle; a dependent insert stops after the line basis. A full
// line basis answers without walking either basis. A restart walks the
// current sum basis once per target.
// in_ready is high only while the sequencer is idle.
// Reset: the sequencer seeds the sum basis from the reset targets with
// in_ready low; no response is produced for this.
// Stall: a response waits in the output register; a finished request waits
// in its last state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module gf2_tensor_span_tracker #(
  parameter int LINE_CAP = gts_pkg::LINE_CAP_DEF,
  parameter int SUM_CAP  = gts_pkg::SUM_CAP_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gts_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gts_pkg::out_rsp_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata
);

  localparam int MAX_CAP = (LINE_CAP > SUM_CAP) ? LINE_CAP : SUM_CAP;
  localparam int CW      = $clog2(MAX_CAP + 1);
  localparam int LAW     = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int SAW     = (SUM_CAP > 1) ? $clog2(SUM_CAP) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LINE = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_TGT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [2:0]               tgt_r, tgt_nxt;
  logic [15:0]              vec_r, vec_nxt;
  logic                     restart_r, restart_nxt;
  logic                     boot_r, boot_nxt;
  logic [CW-1:0]            line_dim_r, line_dim_nxt;
  logic [CW-1:0]            sum_dim_r, sum_dim_nxt;
  logic [3:0]               hit_r, hit_nxt;
  logic [1:0]               status_r, status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gts_pkg::out_rsp_t        out_data_r, out_data_nxt;
  logic [3:0][15:0]         tvec_r;
  logic [2:0]               tcount_r;

  logic                     line_we, sum_we;
  gts_pkg::basis_entry_t    line_rd, sum_rd, new_entry, step_entry;
  gts_pkg::step_res_t       step;
  logic                     step_apply;
  logic [2:0]               tgt_limit;
  logic [15:0]              tgt_vec;
  logic                     load_out;

  // Target registers, written through the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvec_r   <= gts_pkg::RESET_TARGETS;
      tcount_r <= gts_pkg::RESET_TCOUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        gts_pkg::REG_TVEC0:  tvec_r[0] <= cfg_wdata;
        gts_pkg::REG_TVEC1:  tvec_r[1] <= cfg_wdata;
        gts_pkg::REG_TVEC2:  tvec_r[2] <= cfg_wdata;
        gts_pkg::REG_TVEC3:  tvec_r[3] <= cfg_wdata;
        gts_pkg::REG_TCOUNT: tcount_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // The seeding pass after reset always uses the reset targets.
  always_comb begin
    if (boot_r) begin
      tgt_limit = gts_pkg::MAX_TARGETS;
      tgt_vec   = gts_pkg::RESET_TARGETS[tgt_r[1:0]];
    end else begin
      tgt_limit = (tcount_r > gts_pkg::MAX_TARGETS) ? gts_pkg::MAX_TARGETS : tcount_r;
      tgt_vec   = tvec_r[tgt_r[1:0]];
    end
  end

  // Basis storage. Reads use the next index, so the entry for idx_r is
  // ready in the cycle that works on it.
  gts_basis_file #(.DEPTH(LINE_CAP), .AW(LAW)) u_line_file (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_dim_r[LAW-1:0]),
    .wdata (new_entry),
    .raddr (idx_nxt[LAW-1:0]),
    .rdata (line_rd)
  );

  gts_basis_file #(.DEPTH(SUM_CAP), .AW(SAW)) u_sum_file (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_dim_r[SAW-1:0]),
    .wdata (new_entry),
    .raddr (idx_nxt[SAW-1:0]),
    .rdata (sum_rd)
  );

  // The shared step unit works on the line basis or the sum basis.
  always_comb begin
    if (state_r == S_LINE) begin
      step_entry = line_rd;
      step_apply = (idx_r < line_dim_r);
    end else begin
      step_entry = sum_rd;
      step_apply = (state_r == S_SUM) && (idx_r < sum_dim_r);
    end
  end

  gts_step_unit u_step (
    .vec   (vec_r),
    .entry (step_entry),
    .apply (step_apply),
    .res   (step)
  );

  assign new_entry = '{vec: vec_r, piv: step.low_bit};

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    tgt_nxt      = tgt_r;
    vec_nxt      = vec_r;
    restart_nxt  = restart_r;
    boot_nxt     = boot_r;
    line_dim_nxt = line_dim_r;
    sum_dim_nxt  = sum_dim_r;
    hit_nxt      = hit_r;
    status_nxt   = status_r;
    line_we      = 1'b0;
    sum_we       = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == gts_pkg::FUNC_RESTART) begin
            line_dim_nxt = '0;
            sum_dim_nxt  = '0;
            hit_nxt      = 4'd0;
            tgt_nxt      = 3'd0;
            restart_nxt  = 1'b1;
            state_nxt    = S_TGT;
          end else if (line_dim_r == CW'(LINE_CAP)) begin
            status_nxt = gts_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            vec_nxt     = gts_pkg::outer_product(in_data.left_factor, in_data.right_factor);
            idx_nxt     = '0;
            restart_nxt = 1'b0;
            state_nxt   = S_LINE;
          end
        end
      end
      S_LINE: begin
        if (idx_r < line_dim_r) begin
          vec_nxt = step.vec;
          idx_nxt = idx_r + 1'b1;
        end else if (step.is_zero) begin
          status_nxt = gts_pkg::ST_DEP;
          state_nxt  = S_DONE;
        end else begin
          line_we      = 1'b1;
          line_dim_nxt = line_dim_r + 1'b1;
          idx_nxt      = '0;
          state_nxt    = S_SUM;
        end
      end
      S_SUM: begin
        if (idx_r < sum_dim_r) begin
          vec_nxt = step.vec;
          idx_nxt = idx_r + 1'b1;
        end else begin
          if (!step.is_zero && (sum_dim_r < CW'(SUM_CAP))) begin
            sum_we      = 1'b1;
            sum_dim_nxt = sum_dim_r + 1'b1;
          end
          if (restart_r) begin
            tgt_nxt   = tgt_r + 1'b1;
            state_nxt = S_TGT;
          end else if (step.is_zero) begin
            status_nxt = gts_pkg::ST_HIT;
            if (hit_r != 4'hF) begin
              hit_nxt = hit_r + 1'b1;
            end
            state_nxt = S_DONE;
          end else begin
            status_nxt = gts_pkg::ST_EXT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_TGT: begin
        if (tgt_r < tgt_limit) begin
          vec_nxt   = tgt_vec;
          idx_nxt   = '0;
          state_nxt = S_SUM;
        end else if (boot_r) begin
          boot_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          status_nxt = gts_pkg::ST_DEP;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = status_r;
      out_data_nxt.line_count = gts_pkg::sat15(5'(line_dim_r));
      out_data_nxt.sum_dim    = gts_pkg::sat15(5'(sum_dim_r));
      out_data_nxt.hit_count  = hit_r;
    end
  end

  // Control state; reset starts the seeding pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_TGT;
      idx_r       <= '0;
      tgt_r       <= 3'd0;
      restart_r   <= 1'b1;
      boot_r      <= 1'b1;
      line_dim_r  <= '0;
      sum_dim_r   <= '0;
      hit_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      tgt_r       <= tgt_nxt;
      restart_r   <= restart_nxt;
      boot_r      <= boot_nxt;
      line_dim_r  <= line_dim_nxt;
      sum_dim_r   <= sum_dim_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    vec_r      <= vec_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill counts never pass the capacities.
  assert property (@(posedge clk) disable iff (!rst_n)
    (line_dim_r <= CW'(LINE_CAP)) && (sum_dim_r <= CW'(SUM_CAP)))
    else $error("basis fill count above capacity");

  // An accepted request keeps the sequencer busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer ready right after accepting a request");

  // A full status is only reported with a full line basis.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == gts_pkg::ST_FULL) |->
      (out_data.line_count == gts_pkg::sat15(5'(LINE_CAP))))
    else $error("full status with a line basis that is not full");

  // A hit is always counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == gts_pkg::ST_HIT) |-> (out_data.hit_count != 4'd0))
    else $error("hit status with a zero hit count");

endmodule

`default_nettype wire
